@@ rtl/gdcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdcc_pkg
// Shared types, codes and the round/saturate helper of the gated depthwise
// causal convolution block.
// ----------------------------------------------------------------------------
package gdcc_pkg;

   localparam int DATA_W = 16;
   localparam int PROD_W = 32;
   localparam int ACC_W  = 40;
   localparam int CH_W   = 8;
   localparam int TAP_W  = 4;

   localparam int unsigned SHIFT_Q12 = 12;
   localparam int unsigned SHIFT_Q14 = 14;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic signed [ACC_W-1:0] SAT_MAX = 40'sd32767;
   localparam logic signed [ACC_W-1:0] SAT_MIN = -40'sd32768;

   typedef struct packed {
      logic                     sat;
      logic signed [DATA_W-1:0] value;
   } rnd_type;

   // Controller to datapath
   typedef struct packed {
      logic clr_step;   // write one zero entry of the history memory
      logic load_wr;    // write the incoming weight
      logic capture;    // latch a sample item
      logic mul_bh;     // multiply b_gate by h_value
      logic rnd_y;      // round the gated input
      logic tap_issue;  // issue one tap read into the MAC pipeline
      logic rnd_z;      // round the accumulated sum
      logic mul_cz;     // multiply c_gate by z
      logic out_load;   // load the result register
   } gdcc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;
      logic ch_ok;
      logic tap_ok;
      logic last_tap;
      logic pipe_busy;
      logic out_free;
   } gdcc_status_type;

   // Add half an LSB, floor shift, then clamp to 16 bits signed.
   function automatic rnd_type round_sat(input logic signed [ACC_W-1:0] x,
                                         input int unsigned sh);
      logic signed [ACC_W-1:0] half;
      logic signed [ACC_W-1:0] r;
      rnd_type                 o;
      half = ACC_W'(1) << (sh - 1);
      r = x + half;
      r = r >>> sh;
      if (r > SAT_MAX) begin
         o.sat   = 1'b1;
         o.value = 16'sh7fff;
      end else if (r < SAT_MIN) begin
         o.sat   = 1'b1;
         o.value = 16'sh8000;
      end else begin
         o.sat   = 1'b0;
         o.value = r[DATA_W-1:0];
      end
      return o;
   endfunction

endpackage

@@ rtl/gdcc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdcc_ctrl
// Sequencer: history clearing pass after reset, item intake, then the gate
// multiply, tap MAC loop, output multiply and result hand-off.
// ----------------------------------------------------------------------------
module gdcc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_func,
   output logic                     req_stall,
   input  gdcc_pkg::gdcc_status_type status,
   output gdcc_pkg::gdcc_cmd_type    cmd
);
   import gdcc_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL_Y,
      ST_RND_Y,
      ST_MAC,
      ST_DRAIN,
      ST_RND_Z,
      ST_MUL_O,
      ST_OUTPUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && status.ch_ok) begin
               if (req_func == FUNC_LOAD) begin
                  cmd.load_wr = status.tap_ok;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ST_MUL_Y;
               end
            end
         end
         ST_MUL_Y: begin
            cmd.mul_bh = 1'b1;
            state_in   = ST_RND_Y;
         end
         ST_RND_Y: begin
            cmd.rnd_y = 1'b1;
            state_in  = ST_MAC;
         end
         ST_MAC: begin
            cmd.tap_issue = 1'b1;
            if (status.last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_RND_Z;
            end
         end
         ST_RND_Z: begin
            cmd.rnd_z = 1'b1;
            state_in  = ST_MUL_O;
         end
         ST_MUL_O: begin
            cmd.mul_cz = 1'b1;
            state_in   = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            // hold until the result register can take the item
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC && !status.last_tap) |=> state_ff == ST_MAC)
      else $error("tap loop left early");

   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> req_func == FUNC_SAMPLE && status.ch_ok)
      else $error("capture of a non-sample item");

   assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> $past(state_ff) == ST_CLEAR || $past(state_ff) == ST_OUTPUT)
      else $error("intake reopened mid-item");

endmodule

@@ rtl/gdcc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdcc_datapath
// Weight and history memories, shared 16x16 multiplier, tap MAC pipeline,
// rounding and the result register.
// ----------------------------------------------------------------------------
module gdcc_datapath #(
   parameter int CHANNELS = 256,
   parameter int TAPS     = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gdcc_pkg::gdcc_cmd_type           cmd,
   output gdcc_pkg::gdcc_status_type        status,
   input  logic [gdcc_pkg::CH_W-1:0]        req_channel,
   input  logic [gdcc_pkg::TAP_W-1:0]       req_tap,
   input  logic signed [gdcc_pkg::DATA_W-1:0] req_weight,
   input  logic signed [gdcc_pkg::DATA_W-1:0] req_b_gate,
   input  logic signed [gdcc_pkg::DATA_W-1:0] req_c_gate,
   input  logic signed [gdcc_pkg::DATA_W-1:0] req_h_value,
   input  logic                            req_seq_start,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [gdcc_pkg::DATA_W-1:0] rsp_out_value,
   output logic [gdcc_pkg::CH_W-1:0]        rsp_out_channel,
   output logic                            rsp_saturated
);
   import gdcc_pkg::*;

   localparam int WDEPTH = CHANNELS * TAPS;
   localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int HROWS  = (TAPS > 1) ? TAPS - 1 : 1;
   localparam int HDEPTH = CHANNELS * HROWS;
   localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
   localparam int TW     = (TAPS > 1) ? $clog2(TAPS) : 1;

   logic signed [DATA_W-1:0] wmem [WDEPTH];
   logic signed [DATA_W-1:0] hmem [HDEPTH];

   logic [CH_W-1:0]          ch_ff;
   logic signed [DATA_W-1:0] b_ff, c_ff, h_ff;
   logic                     seq_ff;
   logic [WAW-1:0]           wbase_ff;
   logic [HAW-1:0]           hbase_ff;
   logic [TW-1:0]            tap_cnt_ff;
   logic [HAW-1:0]           clr_cnt_ff;

   logic signed [DATA_W-1:0] w_rdata_ff, h_rdata_ff;
   logic                     s1_vld_ff, s2_vld_ff;
   logic [TW-1:0]            s1_tap_ff;
   logic signed [PROD_W-1:0] mult_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [DATA_W-1:0] y_ff, z_ff;
   logic                     sat_ff;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic [CH_W-1:0]          rsp_channel_ff;
   logic                     rsp_sat_ff;

   logic [WAW-1:0]           w_wr_addr, w_rd_addr;
   logic [HAW-1:0]           h_rd_addr, h_wr_addr, h_idx;
   logic                     h_we;
   logic signed [DATA_W-1:0] x_val;
   logic signed [DATA_W-1:0] op_a, op_b;
   logic signed [ACC_W-1:0]  mult_ext;
   rnd_type                  prod_rnd, acc_rnd;

   assign status.clr_last  = (clr_cnt_ff == HAW'(HDEPTH - 1));
   assign status.ch_ok     = (32'(req_channel) < 32'(CHANNELS));
   assign status.tap_ok    = (32'(req_tap) < 32'(TAPS));
   assign status.last_tap  = (tap_cnt_ff == TW'(TAPS - 1));
   assign status.pipe_busy = s1_vld_ff || s2_vld_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign w_wr_addr = WAW'(req_channel) * WAW'(TAPS) + WAW'(req_tap);
   assign w_rd_addr = wbase_ff + WAW'(TAPS - 1) - WAW'(tap_cnt_ff);
   assign h_idx     = (tap_cnt_ff == '0) ? '0 : HAW'(tap_cnt_ff - TW'(1));
   assign h_rd_addr = hbase_ff + h_idx;

   // Tap 0 pairs with the fresh gated input, later taps with history.
   assign x_val = (s1_tap_ff == '0) ? y_ff : (seq_ff ? '0 : h_rdata_ff);
   assign h_we  = s1_vld_ff && (32'(s1_tap_ff) < 32'(TAPS - 1));
   assign h_wr_addr = cmd.clr_step ? clr_cnt_ff : hbase_ff + HAW'(s1_tap_ff);

   always_comb begin
      priority if (cmd.mul_bh) begin
         op_a = b_ff;
         op_b = h_ff;
      end else if (cmd.mul_cz) begin
         op_a = c_ff;
         op_b = z_ff;
      end else begin
         op_a = w_rdata_ff;
         op_b = x_val;
      end
   end

   assign mult_ext = {{(ACC_W - PROD_W){mult_ff[PROD_W-1]}}, mult_ff};
   assign prod_rnd = round_sat(mult_ext, SHIFT_Q12);
   assign acc_rnd  = round_sat(acc_ff, SHIFT_Q14);

   // Memories
   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         wmem[w_wr_addr] <= req_weight;
      end
      w_rdata_ff <= wmem[w_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         hmem[h_wr_addr] <= '0;
      end else if (h_we) begin
         hmem[h_wr_addr] <= x_val;
      end
      h_rdata_ff <= hmem[h_rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         tap_cnt_ff   <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + HAW'(1);
         end
         if (cmd.capture) begin
            tap_cnt_ff <= '0;
         end else if (cmd.tap_issue) begin
            tap_cnt_ff <= tap_cnt_ff + TW'(1);
         end
         s1_vld_ff <= cmd.tap_issue;
         s2_vld_ff <= s1_vld_ff;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_tap_ff <= tap_cnt_ff;
      if (cmd.capture) begin
         ch_ff    <= req_channel;
         b_ff     <= req_b_gate;
         c_ff     <= req_c_gate;
         h_ff     <= req_h_value;
         seq_ff   <= req_seq_start;
         wbase_ff <= WAW'(req_channel) * WAW'(TAPS);
         hbase_ff <= HAW'(req_channel) * HAW'(HROWS);
         acc_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         if (cmd.rnd_y) begin
            y_ff   <= prod_rnd.value;
            sat_ff <= sat_ff | prod_rnd.sat;
         end
         if (cmd.rnd_z) begin
            z_ff   <= acc_rnd.value;
            sat_ff <= sat_ff | acc_rnd.sat;
         end
         if (s2_vld_ff) begin
            acc_ff <= acc_ff + mult_ext;
         end
      end
      if (cmd.mul_bh || cmd.mul_cz || s1_vld_ff) begin
         mult_ff <= op_a * op_b;
      end
      if (cmd.out_load) begin
         rsp_value_ff   <= prod_rnd.value;
         rsp_channel_ff <= ch_ff;
         rsp_sat_ff     <= sat_ff | prod_rnd.sat;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_out_channel = rsp_channel_ff;
   assign rsp_saturated   = rsp_sat_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

   assert property (@(posedge clock) disable iff (reset)
      cmd.tap_issue |-> (32'(tap_cnt_ff) <= 32'(TAPS - 1)))
      else $error("tap counter past last tap");

   assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_step && s1_vld_ff))
      else $error("history clear collides with history update");

   assert property (@(posedge clock) disable iff (reset)
      cmd.rnd_z |-> !s1_vld_ff && !s2_vld_ff)
      else $error("sum rounded before MAC drained");

endmodule

@@ rtl/gated_depthwise_causal_conv_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_depthwise_causal_conv_top
// Per-channel gated causal FIR with Q4.12 data and Q2.14 tap weights.
//
// req_* channel: a load item (func 0) writes one tap weight of one channel;
// a sample item (func 1) computes out = c * sum(w * history) with y = b * h
// entering the channel history. Items with an out-of-range channel, and
// loads with an out-of-range tap, are dropped without a result.
// rsp_* channel: one item per sample, with channel and a saturation flag.
// Both channels move an item when valid is high and stall is low.
// Loads are taken back to back. A sample holds the intake from accept until
// its result is loaded, while the single shared multiplier steps through
// the gate, each tap and the output product.
// Reset: the history memory, CHANNELS * max(TAPS - 1, 1) entries, is swept
// to zero, one entry per cycle; req_stall stays high meanwhile.
// Weights are not cleared and must be loaded before use.
// A stalled result waits in its output register; the block finishes the
// next sample and holds it until that register frees.
// ----------------------------------------------------------------------------
module gated_depthwise_causal_conv_top #(
   parameter int CHANNELS = 256,
   parameter int TAPS     = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [gdcc_pkg::CH_W-1:0]          req_channel,
   input  logic [gdcc_pkg::TAP_W-1:0]         req_tap,
   input  logic signed [gdcc_pkg::DATA_W-1:0] req_weight,
   input  logic signed [gdcc_pkg::DATA_W-1:0] req_b_gate,
   input  logic signed [gdcc_pkg::DATA_W-1:0] req_c_gate,
   input  logic signed [gdcc_pkg::DATA_W-1:0] req_h_value,
   input  logic                              req_seq_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [gdcc_pkg::DATA_W-1:0] rsp_out_value,
   output logic [gdcc_pkg::CH_W-1:0]          rsp_out_channel,
   output logic                              rsp_saturated
);
   import gdcc_pkg::*;

   gdcc_cmd_type    cmd;
   gdcc_status_type status;

   gdcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gdcc_datapath #(
      .CHANNELS (CHANNELS),
      .TAPS     (TAPS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_channel     (req_channel),
      .req_tap         (req_tap),
      .req_weight      (req_weight),
      .req_b_gate      (req_b_gate),
      .req_c_gate      (req_c_gate),
      .req_h_value     (req_h_value),
      .req_seq_start   (req_seq_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_channel (rsp_out_channel),
      .rsp_saturated   (rsp_saturated)
   );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gated depthwise causal convolution block.
// Loads tap weights, streams gated samples through directed corner cases and
// random sequences, predicts each result from a local copy of the weights
// and per-channel history, and compares every output item in order while
// both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import gdcc_pkg::*;

   localparam int NUM_CH   = 256;
   localparam int NUM_TAPS = 4;

   typedef struct {
      logic                     func;
      logic [CH_W-1:0]          channel;
      logic [TAP_W-1:0]         tap;
      logic signed [DATA_W-1:0] weight;
      logic signed [DATA_W-1:0] b_gate;
      logic signed [DATA_W-1:0] c_gate;
      logic signed [DATA_W-1:0] h_value;
      logic                     seq_start;
   } conv_req_type;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic [CH_W-1:0]          channel;
      logic                     sat;
   } conv_rsp_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_func = FUNC_LOAD;
   logic [CH_W-1:0]          req_channel = '0;
   logic [TAP_W-1:0]         req_tap = '0;
   logic signed [DATA_W-1:0] req_weight = '0;
   logic signed [DATA_W-1:0] req_b_gate = '0;
   logic signed [DATA_W-1:0] req_c_gate = '0;
   logic signed [DATA_W-1:0] req_h_value = '0;
   logic                     req_seq_start = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_out_value;
   logic [CH_W-1:0]          rsp_out_channel;
   logic                     rsp_saturated;

   // Local copy of block state
   logic signed [DATA_W-1:0] tap_weight [NUM_CH][NUM_TAPS];
   logic signed [DATA_W-1:0] gated_hist [NUM_CH][NUM_TAPS];
   logic [NUM_TAPS-1:0]      weight_loaded [NUM_CH];

   conv_rsp_type   expected_outs[$];
   int             mismatch_count = 0;
   int             burst_left = 0;
   int             stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    cycle_count = 0;

   gated_depthwise_causal_conv_top #(
      .CHANNELS(NUM_CH),
      .TAPS    (NUM_TAPS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_channel    (req_channel),
      .req_tap        (req_tap),
      .req_weight     (req_weight),
      .req_b_gate     (req_b_gate),
      .req_c_gate     (req_c_gate),
      .req_h_value    (req_h_value),
      .req_seq_start  (req_seq_start),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_channel(rsp_out_channel),
      .rsp_saturated  (rsp_saturated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int c = 0; c < NUM_CH; c++) begin
         weight_loaded[c] = '0;
         for (int t = 0; t < NUM_TAPS; t++) begin
            tap_weight[c][t] = '0;
            gated_hist[c][t] = '0;
         end
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t: %s", $realtime, what);
   endtask

   // Round half up by sh bits, then clamp to 16 bits signed.
   function automatic logic signed [DATA_W-1:0] round_clamp(input longint acc,
                                                            input int unsigned sh,
                                                            inout logic sat_flag);
      longint r;
      r = (acc + (longint'(1) <<< (sh - 1))) >>> sh;
      if (r > 32767) begin
         sat_flag = 1'b1;
         return 16'sh7fff;
      end
      if (r < -32768) begin
         sat_flag = 1'b1;
         return 16'sh8000;
      end
      return r[DATA_W-1:0];
   endfunction

   task automatic predict_gated_conv(input conv_req_type it);
      logic                     sat;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
      longint                   acc;
      conv_rsp_type             want;
      if (int'(it.channel) >= NUM_CH)
         return;
      if (it.func == FUNC_LOAD) begin
         if (int'(it.tap) < NUM_TAPS) begin
            tap_weight[it.channel][it.tap] = it.weight;
            weight_loaded[it.channel][it.tap] = 1'b1;
         end
         return;
      end
      if (it.seq_start) begin
         for (int j = 0; j < NUM_TAPS; j++)
            gated_hist[it.channel][j] = '0;
      end
      sat = 1'b0;
      y = round_clamp(longint'(it.b_gate) * longint'(it.h_value), SHIFT_Q12, sat);
      acc = longint'(tap_weight[it.channel][NUM_TAPS-1]) * longint'(y);
      for (int j = 1; j < NUM_TAPS; j++)
         acc += longint'(tap_weight[it.channel][NUM_TAPS-1-j]) *
                longint'(gated_hist[it.channel][j-1]);
      z = round_clamp(acc, SHIFT_Q14, sat);
      want.value = round_clamp(longint'(it.c_gate) * longint'(z), SHIFT_Q12, sat);
      want.channel = it.channel;
      want.sat = sat;
      for (int j = NUM_TAPS - 2; j >= 1; j--)
         gated_hist[it.channel][j] = gated_hist[it.channel][j-1];
      if (NUM_TAPS > 1)
         gated_hist[it.channel][0] = y;
      expected_outs.push_back(want);
   endtask

   function automatic logic signed [DATA_W-1:0] rand_q16();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      case (pick)
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return $urandom_range(0, 1) ? 16'sh0000 : 16'shffff;
         3, 4, 5: return 16'(int'($urandom_range(0, 8192)) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic conv_req_type make_load(input int ch, input int tap,
                                              input logic signed [DATA_W-1:0] w);
      conv_req_type it;
      it.func      = FUNC_LOAD;
      it.channel   = ch[CH_W-1:0];
      it.tap       = tap[TAP_W-1:0];
      it.weight    = w;
      it.b_gate    = 16'($urandom);
      it.c_gate    = 16'($urandom);
      it.h_value   = 16'($urandom);
      it.seq_start = 1'($urandom);
      return it;
   endfunction

   function automatic conv_req_type make_sample(input int ch,
                                                input logic signed [DATA_W-1:0] b,
                                                input logic signed [DATA_W-1:0] c,
                                                input logic signed [DATA_W-1:0] h,
                                                input logic start);
      conv_req_type it;
      it.func      = FUNC_SAMPLE;
      it.channel   = ch[CH_W-1:0];
      it.tap       = 4'($urandom);
      it.weight    = 16'($urandom);
      it.b_gate    = b;
      it.c_gate    = c;
      it.h_value   = h;
      it.seq_start = start;
      return it;
   endfunction

   // Drive one item and hold it until accepted; called right after a rising edge.
   task automatic send_item(input conv_req_type it);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      burst_left--;
      req_func      <= it.func;
      req_channel   <= it.channel;
      req_tap       <= it.tap;
      req_weight    <= it.weight;
      req_b_gate    <= it.b_gate;
      req_c_gate    <= it.c_gate;
      req_h_value   <= it.h_value;
      req_seq_start <= it.seq_start;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_gated_conv(it);
   endtask

   // Receiver: switch between random stall patterns, each held for a random run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(32, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (cycle_count[3:0] < 4'd9);
      endcase
   end

   always @(posedge clock) begin : check_results
      conv_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outs.size() == 0) begin
            report_mismatch($sformatf("unexpected result item on channel %0d",
                                      rsp_out_channel));
         end else begin
            want = expected_outs.pop_front();
            if (rsp_out_value !== want.value)
               report_mismatch($sformatf("ch %0d out_value got %0d want %0d",
                                         want.channel, rsp_out_value, want.value));
            if (rsp_out_channel !== want.channel)
               report_mismatch($sformatf("out_channel got %0d want %0d",
                                         rsp_out_channel, want.channel));
            if (rsp_saturated !== want.sat)
               report_mismatch($sformatf("ch %0d saturated got %0b want %0b",
                                         want.channel, rsp_saturated, want.sat));
         end
      end
   end

   task automatic test_weight_loads();
      send_item(make_load(0, 0, 16'sh8000));
      send_item(make_load(0, 1, 16'sh7fff));
      send_item(make_load(0, 2, 16'shffff));
      send_item(make_load(0, 3, 16'sh4000));
      for (int t = 0; t < NUM_TAPS; t++)
         send_item(make_load(255, t, 16'sh7fff));
   endtask

   // Loads with an out-of-range tap must leave the weights alone.
   task automatic test_ignored_loads();
      send_item(make_load(0, NUM_TAPS, 16'sh0000));
      send_item(make_load(0, 15, 16'sh1234));
   endtask

   task automatic test_extreme_samples();
      // channel 255 relies on the history cleared at reset
      send_item(make_sample(255, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0));
      send_item(make_sample(255, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0));
      send_item(make_sample(255, 16'sh8000, 16'sh0001, 16'sh7fff, 1'b0));
      // exact half LSB on the gated input, positive and negative
      send_item(make_sample(0, 16'sh0001, 16'sh1000, 16'sh0800, 1'b1));
      send_item(make_sample(0, 16'shffff, 16'sh1000, 16'sh0800, 1'b0));
      send_item(make_sample(0, 16'sh0000, 16'sh7fff, 16'sh7fff, 1'b0));
   endtask

   task automatic test_seq_start();
      send_item(make_sample(0, 16'sh1000, 16'sh1000, 16'sh1000, 1'b0));
      send_item(make_sample(0, 16'sh2000, 16'sh1000, 16'shf000, 1'b0));
      send_item(make_sample(0, 16'sh1000, 16'sh1000, 16'sh0800, 1'b1));
      send_item(make_sample(0, 16'sh1000, 16'sh1000, 16'sh0800, 1'b0));
   endtask

   // Mostly sample streams on a few busy channels, with loads and noise mixed in.
   task automatic test_random_traffic(input int n_items);
      int sent;
      int pick;
      int ch;
      int busy_ch [8];
      sent = 0;
      foreach (busy_ch[i])
         busy_ch[i] = $urandom_range(0, NUM_CH - 1);
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         ch = ($urandom_range(0, 9) < 7) ? busy_ch[$urandom_range(0, 7)]
                                         : $urandom_range(0, NUM_CH - 1);
         if (pick < 6) begin
            send_item(make_load(ch, $urandom_range(NUM_TAPS, 15), rand_q16()));
         end else if (pick < 20) begin
            send_item(make_load(ch, $urandom_range(0, NUM_TAPS - 1), rand_q16()));
            sent++;
         end else begin
            // never read a weight that was not written
            for (int t = 0; t < NUM_TAPS; t++) begin
               if (!weight_loaded[ch][t]) begin
                  send_item(make_load(ch, t, rand_q16()));
                  sent++;
               end
            end
            send_item(make_sample(ch, rand_q16(), rand_q16(), rand_q16(),
                                  $urandom_range(0, 7) == 0));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_weight_loads();
      test_ignored_loads();
      test_extreme_samples();
      test_seq_start();
      test_random_traffic(1500);
      req_valid <= 1'b0;
      while (expected_outs.size() != 0)
         @(posedge clock);
      repeat (NUM_TAPS + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ files.f @@
rtl/gdcc_pkg.sv
rtl/gdcc_ctrl.sv
rtl/gdcc_datapath.sv
rtl/gated_depthwise_causal_conv_top.sv
test/tb.sv
